### rtl/rgb_brightness_by_hsv_value_assert.svh
// assertion macros shared by the rgb brightness rtl
`ifndef RGB_BRIGHTNESS_BY_HSV_VALUE_ASSERT_SVH
`define RGB_BRIGHTNESS_BY_HSV_VALUE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define RBHV_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rbhv invariant violated");

// consequent must hold in the same cycle as the antecedent
`define RBHV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbhv implication violated");

`endif

### rtl/rbhv_pkg.sv
// types and constants for the rgb brightness block
`default_nettype none

package rbhv_pkg;

    localparam int CHAN_W    = 8;
    localparam int LEVEL_W   = 7;
    localparam int QUO_W     = 8;
    localparam int DEN_W     = 15;
    localparam int REM_W     = 15;
    localparam int PROD_W    = 15;
    localparam int NUM_W     = 23;
    localparam int NUM_LANES = 3;
    localparam int NUM_CELLS = QUO_W;

    localparam int FULL_SCALE = 255;
    localparam int PCT_MIN    = 1;
    localparam int PCT_MAX    = 100;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    // one channel's partial division
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
    } lane_t;

    // word handed from cell to cell
    typedef struct packed {
        logic [DEN_W-1:0]                 den;
        lane_t [NUM_LANES-1:0]            lane;
    } div_word_t;

endpackage

`default_nettype wire

### rtl/rbhv_in_if.sv
// pixel input channel
`default_nettype none

interface rbhv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [6:0] level;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output level, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input level, output ready);
endinterface

`default_nettype wire

### rtl/rbhv_out_if.sv
// adjusted pixel output channel
`default_nettype none

interface rbhv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

`default_nettype wire

### rtl/rbhv_front.sv
// level clamp, max channel and dividend/divisor products (two stages)
`default_nettype none
`include "rgb_brightness_by_hsv_value_assert.svh"

module rbhv_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               red,
    input  wire logic [7:0]               green,
    input  wire logic [7:0]               blue,
    input  wire logic [6:0]               level,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output rbhv_pkg::div_word_t           out_data
);
    import rbhv_pkg::*;

    logic                                  a_valid_reg;
    logic [LEVEL_W-1:0]                    a_lv_reg;
    logic [LEVEL_W-1:0]                    a_lv_next;
    logic [CHAN_W-1:0]                     a_mx_reg;
    logic [CHAN_W-1:0]                     a_mx_next;
    logic [NUM_LANES-1:0][CHAN_W-1:0]      a_chan_reg;
    logic [NUM_LANES-1:0][CHAN_W-1:0]      a_chan_next;
    logic                                  a_ready;

    logic                                  b_valid_reg;
    div_word_t                             b_data_reg;
    div_word_t                             b_data_next;
    logic                                  b_ready;

    logic [CHAN_W-1:0]                     mx;
    logic [CHAN_W-1:0]                     mn;
    logic [PROD_W-1:0]                     prod [NUM_LANES];
    logic [NUM_W-1:0]                      dividend [NUM_LANES];

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: clamp level, find max/min, fold grey and black onto 1/1
    always_comb
    begin
        if (level == '0)
            a_lv_next = LEVEL_W'(PCT_MIN);
        else if (level > LEVEL_W'(PCT_MAX))
            a_lv_next = LEVEL_W'(PCT_MAX);
        else
            a_lv_next = level;

        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        if (mx == mn)
        begin
            // grey: every channel gets the full new value
            a_mx_next              = CHAN_W'(1);
            a_chan_next[LANE_RED]   = CHAN_W'(1);
            a_chan_next[LANE_GREEN] = CHAN_W'(1);
            a_chan_next[LANE_BLUE]  = CHAN_W'(1);
        end
        else
        begin
            a_mx_next              = mx;
            a_chan_next[LANE_RED]   = red;
            a_chan_next[LANE_GREEN] = green;
            a_chan_next[LANE_BLUE]  = blue;
        end
    end

    // stage b: dividend lv*255*c, divisor 100*max
    always_comb
    begin
        b_data_next.den = DEN_W'(a_mx_reg) * DEN_W'(PCT_MAX);
        for (int k = 0; k < NUM_LANES; k++)
        begin
            prod[k]     = PROD_W'(a_lv_reg) * PROD_W'(a_chan_reg[k]);
            dividend[k] = {prod[k], {QUO_W{1'b0}}} - NUM_W'(prod[k]);
            b_data_next.lane[k].rem = dividend[k][NUM_W-1:QUO_W];
            b_data_next.lane[k].num = dividend[k][QUO_W-1:0];
            b_data_next.lane[k].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_lv_reg   <= a_lv_next;
            a_mx_reg   <= a_mx_next;
            a_chan_reg <= a_chan_next;
        end
        if (b_ready)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    `RBHV_ASSERT_HOLDS(a_max_nonzero, clk, rst_n, !a_valid_reg || (a_mx_reg != '0))
    `RBHV_ASSERT_IMPLIES(a_den_nonzero, clk, rst_n, b_valid_reg, b_data_reg.den != '0)

endmodule

`default_nettype wire

### rtl/rbhv_div_cell.sv
// one restoring division step for all three channels
`default_nettype none
`include "rgb_brightness_by_hsv_value_assert.svh"

module rbhv_div_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire rbhv_pkg::div_word_t      in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output rbhv_pkg::div_word_t           out_data
);
    import rbhv_pkg::*;

    logic                  valid_reg;
    div_word_t             data_reg;
    div_word_t             data_next;
    logic [REM_W:0]        trial [NUM_LANES];
    logic [REM_W:0]        diff [NUM_LANES];
    logic                  fits [NUM_LANES];

    assign in_ready = !valid_reg || out_ready;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        data_next.den = in_data.den;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            trial[k] = {in_data.lane[k].rem, in_data.lane[k].num[QUO_W-1]};
            diff[k]  = trial[k] - {1'b0, in_data.den};
            fits[k]  = trial[k] >= {1'b0, in_data.den};
            data_next.lane[k].rem = fits[k] ? diff[k][REM_W-1:0] : trial[k][REM_W-1:0];
            data_next.lane[k].num = {in_data.lane[k].num[QUO_W-2:0], 1'b0};
            data_next.lane[k].quo = {in_data.lane[k].quo[QUO_W-2:0], fits[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `RBHV_ASSERT_IMPLIES(a_red_rem_below, clk, rst_n, valid_reg, data_reg.lane[LANE_RED].rem < data_reg.den)
    `RBHV_ASSERT_IMPLIES(a_green_rem_below, clk, rst_n, valid_reg, data_reg.lane[LANE_GREEN].rem < data_reg.den)
    `RBHV_ASSERT_IMPLIES(a_blue_rem_below, clk, rst_n, valid_reg, data_reg.lane[LANE_BLUE].rem < data_reg.den)

endmodule

`default_nettype wire

### rtl/rgb_brightness_by_hsv_value.sv
// rgb pixel brightness by hsv value replacement, top level
// usage:
//   pixel (sink): one rgb pixel plus a brightness level in percent per
//     transaction; level 0 acts as 1, levels above 100 act as 100
//   adjusted (source): the pixel with hue and saturation kept and its
//     largest channel set to floor(level*255/100); every channel is
//     floor(level*255*c / (100*max)), grey and black give that value on
//     all three channels
//   pipeline: 2 front stages plus 8 division cells, one quotient bit per
//     cell, between an accepted pixel transaction and valid on adjusted
//   throughput: one pixel per clock while the receiver keeps ready high;
//     every stage is a pipeline register with its own valid bit, so
//     bubbles are squeezed out and pixel keeps taking transactions while
//     adjusted holds a result, until the chain has filled up
//   stall: adjusted holds its data while ready is low; pixel.ready is the
//     ready chain through all stages, so it falls only when all are full
//   reset: rst_n clears all valid bits at once, the chain comes up empty
//     and ready; nothing else is kept between pixels
`default_nettype none

module rgb_brightness_by_hsv_value (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbhv_in_if.sink     pixel,
    rbhv_out_if.source  adjusted
);
    import rbhv_pkg::*;

    // node k feeds cell k, node NUM_CELLS is the output register
    logic                 node_valid [NUM_CELLS+1];
    logic                 node_ready [NUM_CELLS+1];
    div_word_t            node_data  [NUM_CELLS+1];

    // clamp, max channel and the two products
    rbhv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .red       (pixel.red_in),
        .green     (pixel.green_in),
        .blue      (pixel.blue_in),
        .level     (pixel.level),
        .out_valid (node_valid[0]),
        .out_ready (node_ready[0]),
        .out_data  (node_data[0])
    );

    // row of division cells, msb of the quotient first
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        rbhv_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (node_valid[k]),
            .in_ready  (node_ready[k]),
            .in_data   (node_data[k]),
            .out_valid (node_valid[k+1]),
            .out_ready (node_ready[k+1]),
            .out_data  (node_data[k+1])
        );
    end

    // last cell's register drives the output channel directly
    assign node_ready[NUM_CELLS] = adjusted.ready;
    assign adjusted.valid        = node_valid[NUM_CELLS];
    assign adjusted.red_out      = node_data[NUM_CELLS].lane[LANE_RED].quo;
    assign adjusted.green_out    = node_data[NUM_CELLS].lane[LANE_GREEN].quo;
    assign adjusted.blue_out     = node_data[NUM_CELLS].lane[LANE_BLUE].quo;

endmodule

`default_nettype wire

### sim/tb_top.sv
// testbench for the rgb brightness by hsv value block: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module tb_top;

    import rbhv_pkg::*;

    // receiver hold-off length for the fill-up phase
    localparam int unsigned HOLD_CYCLES    = 200;
    // cycles with no transaction on either side before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // settle time after the last result
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned RANDOM_PIXELS  = 850;
    localparam int unsigned BLOCK_PIXELS   = 50;
    localparam int unsigned FILL_PIXELS    = 40;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    // holds the adjusted pixels still owed by the block, oldest first
    class pixel_scoreboard;
        rgb_t        owed_q[$];
        int unsigned mismatches;
        int unsigned n_noted;
        int unsigned n_checked;
        int unsigned n_grey;
        int unsigned n_clamped;

        function new();
            mismatches = 0;
            n_noted    = 0;
            n_checked  = 0;
            n_grey     = 0;
            n_clamped  = 0;
        endfunction

        // value replaced by the saturated level, hue and saturation kept
        function rgb_t brighten(chan_t r, chan_t g, chan_t b, level_t lv_raw);
            int unsigned lv;
            int unsigned mx;
            int unsigned mn;
            rgb_t        res;
            lv = lv_raw;
            if (lv < PCT_MIN)
                lv = PCT_MIN;
            if (lv > PCT_MAX)
                lv = PCT_MAX;
            mx = r;
            if (g > mx)
                mx = g;
            if (b > mx)
                mx = b;
            mn = r;
            if (g < mn)
                mn = g;
            if (b < mn)
                mn = b;
            if (mx == mn)
            begin
                // grey and black: every channel lands on the full value
                res.red   = chan_t'((lv * FULL_SCALE) / PCT_MAX);
                res.green = res.red;
                res.blue  = res.red;
            end
            else
            begin
                res.red   = chan_t'((lv * FULL_SCALE * r) / (PCT_MAX * mx));
                res.green = chan_t'((lv * FULL_SCALE * g) / (PCT_MAX * mx));
                res.blue  = chan_t'((lv * FULL_SCALE * b) / (PCT_MAX * mx));
            end
            return res;
        endfunction

        function void note_pixel(chan_t r, chan_t g, chan_t b, level_t lv);
            owed_q.push_back(brighten(r, g, b, lv));
            n_noted++;
            if (r == g && g == b)
                n_grey++;
            if (lv < PCT_MIN || lv > PCT_MAX)
                n_clamped++;
        endfunction

        function void check_adjusted(chan_t r, chan_t g, chan_t b);
            rgb_t exp_px;
            if (owed_q.size() == 0)
            begin
                $error("adjusted: result with no pixel outstanding (%0d %0d %0d)", r, g, b);
                mismatches++;
                return;
            end
            exp_px = owed_q.pop_front();
            n_checked++;
            if (r !== exp_px.red)
            begin
                $error("red_out: expected %0d, actual %0d", exp_px.red, r);
                mismatches++;
            end
            if (g !== exp_px.green)
            begin
                $error("green_out: expected %0d, actual %0d", exp_px.green, g);
                mismatches++;
            end
            if (b !== exp_px.blue)
            begin
                $error("blue_out: expected %0d, actual %0d", exp_px.blue, b);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    // bumped by the stimulus to ask the receiver for one long hold-off
    int unsigned hold_reqs = 0;

    pixel_scoreboard sb = new();

    rbhv_in_if  pix_if();
    rbhv_out_if adj_if();

    rgb_brightness_by_hsv_value DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pix_if),
        .adjusted (adj_if)
    );

    // free running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one pixel and hold it until the transaction completes;
    // always entered right after a rising edge
    task automatic offer_pixel(input chan_t r, input chan_t g, input chan_t b,
                               input level_t lv);
        pix_if.valid    <= 1'b1;
        pix_if.red_in   <= r;
        pix_if.green_in <= g;
        pix_if.blue_in  <= b;
        pix_if.level    <= lv;
        do
            @(posedge clk);
        while (!pix_if.ready);
        sb.note_pixel(r, g, b, lv);
    endtask

    // drop valid for a number of cycles; the payload wanders meanwhile and
    // must be ignored by the block
    task automatic idle_gap(input int unsigned n);
        if (n > 0)
        begin
            pix_if.valid    <= 1'b0;
            pix_if.red_in   <= chan_t'($urandom);
            pix_if.green_in <= chan_t'($urandom);
            pix_if.blue_in  <= chan_t'($urandom);
            pix_if.level    <= level_t'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // stop offering until every owed result has come back
    task automatic drain_pipeline();
        pix_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() > 0);
    endtask

    // one random pixel, biased toward the interesting corners
    task automatic send_random_pixel(input bit gapless);
        int unsigned sel;
        int unsigned lane;
        chan_t       r;
        chan_t       g;
        chan_t       b;
        level_t      lv;
        sel = $urandom_range(0, 99);
        r   = chan_t'($urandom);
        g   = chan_t'($urandom);
        b   = chan_t'($urandom);
        lv  = level_t'($urandom);
        if (sel < 15)
        begin
            // grey pixel, sometimes black
            if ($urandom_range(0, 3) == 0)
                r = '0;
            g = r;
            b = r;
        end
        else if (sel < 30)
        begin
            // level at or beyond the saturation points
            case ($urandom_range(0, 4))
                0:       lv = '0;
                1:       lv = level_t'(PCT_MIN);
                2:       lv = level_t'(PCT_MAX);
                3:       lv = level_t'($urandom_range(PCT_MAX + 1, 127));
                default: lv = '1;
            endcase
        end
        else if (sel < 45)
        begin
            // one channel pinned to full scale or zero
            lane = $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 0)
            begin
                if (lane == 0) r = '1; else if (lane == 1) g = '1; else b = '1;
            end
            else
            begin
                if (lane == 0) r = '0; else if (lane == 1) g = '0; else b = '0;
            end
        end
        else if (sel < 55)
        begin
            // tiny channels, where the floor matters most
            r = chan_t'($urandom_range(0, 3));
            g = chan_t'($urandom_range(0, 3));
            b = chan_t'($urandom_range(0, 3));
        end
        else if (sel < 60)
        begin
            // red and green tie, not always for the largest
            g = r;
        end
        offer_pixel(r, g, b, lv);
        idle_gap(gapless ? 0 : pick_gap());
    endtask

    // receiver: random ready pattern with long free runs, plus the
    // requested hold-off that it counts on its own
    initial
    begin : adjusted_sink
        int unsigned run_left;
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        holds_seen = 0;
        adj_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (adj_if.valid && adj_if.ready)
                sb.check_adjusted(adj_if.red_out, adj_if.green_out, adj_if.blue_out);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                adj_if.ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                adj_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                adj_if.ready <= 1'b0;
            end
            else
            begin
                // new ready run, now and then a long one with no idling
                if ($urandom_range(0, 5) == 0)
                    run_left = $urandom_range(100, 300);
                else
                    run_left = $urandom_range(1, 30);
                if ($urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(10, 50);
                else
                    stall_left = $urandom_range(1, 3);
                run_left--;
                adj_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: give up once no transaction has moved for too long
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (adj_if.valid && adj_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: watchdog expired after %0d cycles with no transaction", idle_cycles);
        $display("tb: failure");
        $finish;
    end

    // main stimulus
    initial
    begin : stimulus
        bit gapless;
        rst_n           = 1'b0;
        pix_if.valid    <= 1'b0;
        pix_if.red_in   <= '0;
        pix_if.green_in <= '0;
        pix_if.blue_in  <= '0;
        pix_if.level    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: black, grey, white, pure colors, ties, tiny
        // channels and both level saturation points
        offer_pixel(8'd0,   8'd0,   8'd0,   7'd50);
        offer_pixel(8'd0,   8'd0,   8'd0,   7'd0);
        offer_pixel(8'd255, 8'd255, 8'd255, 7'd127);
        offer_pixel(8'd128, 8'd128, 8'd128, 7'd1);
        offer_pixel(8'd255, 8'd0,   8'd0,   7'd100);
        offer_pixel(8'd0,   8'd255, 8'd0,   7'd100);
        offer_pixel(8'd0,   8'd0,   8'd255, 7'd100);
        offer_pixel(8'd255, 8'd128, 8'd0,   7'd50);
        offer_pixel(8'd1,   8'd0,   8'd0,   7'd100);
        offer_pixel(8'd0,   8'd0,   8'd1,   7'd37);
        offer_pixel(8'd254, 8'd255, 8'd253, 7'd99);
        offer_pixel(8'd200, 8'd200, 8'd10,  7'd101);
        offer_pixel(8'd10,  8'd200, 8'd200, 7'd0);
        offer_pixel(8'd255, 8'd1,   8'd254, 7'd1);
        offer_pixel(8'd3,   8'd2,   8'd1,   7'd100);
        offer_pixel(8'd170, 8'd85,  8'd255, 7'd127);
        offer_pixel(8'd85,  8'd170, 8'd0,   7'd64);
        offer_pixel(8'd127, 8'd64,  8'd32,  7'd2);
        offer_pixel(8'd255, 8'd255, 8'd0,   7'd100);
        offer_pixel(8'd1,   8'd1,   8'd0,   7'd77);

        // sender pause until the pipeline is empty
        drain_pipeline();

        // receiver holds off while pixels keep coming, so the chain fills
        // and pixel.ready has to fall
        hold_reqs++;
        repeat (FILL_PIXELS) send_random_pixel(1'b1);
        drain_pipeline();

        // random part in blocks, some of them back to back
        gapless = 1'b0;
        for (int unsigned i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i % BLOCK_PIXELS == 0)
                gapless = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_PIXELS / 2)
            begin
                drain_pipeline();
                hold_reqs++;
            end
            send_random_pixel(gapless);
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d pixels sent, %0d results checked, %0d grey or black, %0d clamped",
                 sb.n_noted, sb.n_checked, sb.n_grey, sb.n_clamped);
        $display("tb: covered random gaps on both sides, long output hold-offs and drains");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
